/* sv/ucc_pkg.sv */
// Shared types, constants and helper functions for the UTF-8 code point codec.
package ucc_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned CNT_W = 3;

  // Action codes
  localparam logic ACT_DECODE = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MAX = 21'h10ffff;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00d800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00dfff;
  localparam logic [CP_W-1:0] LIM_1B = 21'h000080;
  localparam logic [CP_W-1:0] LIM_2B = 21'h000800;
  localparam logic [CP_W-1:0] LIM_3B = 21'h010000;
  localparam logic [CP_W-1:0] INVALID_RESET = 21'h00ffff;

  // Byte marks
  localparam logic [7:0] LEAD2_MARK = 8'hc0;
  localparam logic [7:0] LEAD3_MARK = 8'he0;
  localparam logic [7:0] LEAD4_MARK = 8'hf0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] CONT_MARK = 8'h80;

  // Sequence lengths
  localparam logic [CNT_W-1:0] LEN_CONT = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1 = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2 = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3 = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4 = 3'd4;

  // Classified transaction after the first stage
  typedef struct packed {
    logic            action;
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0] cand;
    logic            use_inv;
  } cls_t;

  // Resolved code point after the second stage
  typedef struct packed {
    logic            action;
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0] point;
  } sel_t;

  // Result transaction
  typedef struct packed {
    logic [CP_W-1:0] point_out;
    logic [7:0]      out_byte0;
    logic [7:0]      out_byte1;
    logic [7:0]      out_byte2;
    logic [7:0]      out_byte3;
    logic [CNT_W-1:0] byte_count;
  } res_t;

  // Sequence length from the lead byte's upper nibble
  function automatic logic [CNT_W-1:0] lead_len(input logic [3:0] nib);
    logic [CNT_W-1:0] len;
    case (nib)
      4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7: len = LEN_1;
      4'hc, 4'hd: len = LEN_2;
      4'he: len = LEN_3;
      4'hf: len = LEN_4;
      default: len = LEN_CONT;
    endcase
    return len;
  endfunction

  function automatic logic is_surrogate(input logic [CP_W-1:0] v);
    return (v >= SURR_LO) && (v <= SURR_HI);
  endfunction

endpackage

/* sv/ucc_classify.sv */
// First stage: classify the transaction and assemble the candidate code point.
module ucc_classify (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                in_byte0,
  input  logic [7:0]                in_byte1,
  input  logic [7:0]                in_byte2,
  input  logic [7:0]                in_byte3,
  input  logic [ucc_pkg::CP_W-1:0]  point_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ucc_pkg::cls_t             out_data
);

  ucc_pkg::cls_t cls_next;
  logic [ucc_pkg::CNT_W-1:0] len;
  logic [ucc_pkg::CP_W-1:0] pt3;

  assign len = ucc_pkg::lead_len(in_byte0[7:4]);
  assign pt3 = {5'd0, in_byte0[3:0], in_byte1[5:0], in_byte2[5:0]};

  // Build candidate value and invalid flag
  always_comb begin
    cls_next.action = action;
    cls_next.cnt = len;
    cls_next.cand = '0;
    cls_next.use_inv = 1'b0;
    if (action == ucc_pkg::ACT_ENCODE) begin
      cls_next.cand = point_in;
      cls_next.use_inv = (point_in > ucc_pkg::CP_MAX) || ucc_pkg::is_surrogate(point_in);
    end else begin
      case (len)
        ucc_pkg::LEN_1: begin
          cls_next.cand = {13'd0, in_byte0};
        end
        ucc_pkg::LEN_2: begin
          cls_next.cand = {10'd0, in_byte0[4:0], in_byte1[5:0]};
        end
        ucc_pkg::LEN_3: begin
          cls_next.cand = pt3;
          cls_next.use_inv = ucc_pkg::is_surrogate(pt3);
        end
        default: begin
          // continuation lead or four-byte lead
          if ((in_byte0 & ucc_pkg::LEAD4_MASK) == ucc_pkg::LEAD4_MARK) begin
            cls_next.cand = {in_byte0[2:0], in_byte1[5:0], in_byte2[5:0], in_byte3[5:0]};
          end else begin
            cls_next.use_inv = 1'b1;
          end
        end
      endcase
    end
  end

  // Hold while the result is stalled
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_data <= cls_next;
    end
  end

endmodule

/* sv/ucc_select.sv */
// Second stage: substitute the invalid value and size the encoded sequence.
module ucc_select (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ucc_pkg::CP_W-1:0]  invalid_value,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ucc_pkg::cls_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ucc_pkg::sel_t             out_data
);

  ucc_pkg::sel_t sel_next;
  logic [ucc_pkg::CP_W-1:0] value;

  assign value = in_data.use_inv ? invalid_value : in_data.cand;

  // Pick the length class for encoding
  always_comb begin
    sel_next.action = in_data.action;
    sel_next.point = value;
    sel_next.cnt = in_data.cnt;
    if (in_data.action == ucc_pkg::ACT_ENCODE) begin
      if (value < ucc_pkg::LIM_1B) begin
        sel_next.cnt = ucc_pkg::LEN_1;
      end else if (value < ucc_pkg::LIM_2B) begin
        sel_next.cnt = ucc_pkg::LEN_2;
      end else if (value < ucc_pkg::LIM_3B) begin
        sel_next.cnt = ucc_pkg::LEN_3;
      end else begin
        sel_next.cnt = ucc_pkg::LEN_4;
      end
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_data <= sel_next;
    end
  end

endmodule

/* sv/ucc_format.sv */
// Third stage: format the result transaction into code point or UTF-8 bytes.
module ucc_format (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ucc_pkg::sel_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ucc_pkg::res_t out_data
);

  ucc_pkg::res_t res_next;
  logic [ucc_pkg::CP_W-1:0] p;

  assign p = in_data.point;

  // Lay out the bytes for the chosen length
  always_comb begin
    res_next = '0;
    res_next.byte_count = in_data.cnt;
    if (in_data.action == ucc_pkg::ACT_DECODE) begin
      res_next.point_out = p;
    end else begin
      case (in_data.cnt)
        ucc_pkg::LEN_1: begin
          res_next.out_byte0 = p[7:0];
        end
        ucc_pkg::LEN_2: begin
          res_next.out_byte0 = ucc_pkg::LEAD2_MARK | {3'd0, p[10:6]};
          res_next.out_byte1 = ucc_pkg::CONT_MARK | {2'd0, p[5:0]};
        end
        ucc_pkg::LEN_3: begin
          res_next.out_byte0 = ucc_pkg::LEAD3_MARK | {4'd0, p[15:12]};
          res_next.out_byte1 = ucc_pkg::CONT_MARK | {2'd0, p[11:6]};
          res_next.out_byte2 = ucc_pkg::CONT_MARK | {2'd0, p[5:0]};
        end
        default: begin
          res_next.out_byte0 = ucc_pkg::LEAD4_MARK | {5'd0, p[20:18]};
          res_next.out_byte1 = ucc_pkg::CONT_MARK | {2'd0, p[17:12]};
          res_next.out_byte2 = ucc_pkg::CONT_MARK | {2'd0, p[11:6]};
          res_next.out_byte3 = ucc_pkg::CONT_MARK | {2'd0, p[5:0]};
        end
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

/* sv/utf8_codepoint_codec_core.sv */
// Top level of the UTF-8 code point codec: config register and three-stage pipeline.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  action, in_byte0..3, point_in
//   output   out        out_valid/out_stall  point_out, out_byte0..3, byte_count
//   config   in         cfg_we               cfg_wdata (invalid_value)
//
// A transaction passes through the three register stages (classify, select,
// format) in turn, each of which loads whenever it is empty or its successor
// moves; one is accepted every cycle while no stall holds the input.
// Reset (synchronous, rst high) empties the pipeline and sets invalid_value to 0xFFFF.
// A stall holds the last stage; earlier stages keep filling their empty slots.
module utf8_codepoint_codec_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ucc_pkg::CP_W-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                in_byte0,
  input  logic [7:0]                in_byte1,
  input  logic [7:0]                in_byte2,
  input  logic [7:0]                in_byte3,
  input  logic [ucc_pkg::CP_W-1:0]  point_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ucc_pkg::CP_W-1:0]  point_out,
  output logic [7:0]                out_byte0,
  output logic [7:0]                out_byte1,
  output logic [7:0]                out_byte2,
  output logic [7:0]                out_byte3,
  output logic [ucc_pkg::CNT_W-1:0] byte_count
);

  logic [ucc_pkg::CP_W-1:0] invalid_value;
  logic cls_valid, cls_stall;
  logic sel_valid, sel_stall;
  ucc_pkg::cls_t cls_data;
  ucc_pkg::sel_t sel_data;
  ucc_pkg::res_t res_data;

  // Write the invalid-value register
  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_value <= ucc_pkg::INVALID_RESET;
    end else if (cfg_we) begin
      invalid_value <= cfg_wdata;
    end
  end

  ucc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .in_byte0  (in_byte0),
    .in_byte1  (in_byte1),
    .in_byte2  (in_byte2),
    .in_byte3  (in_byte3),
    .point_in  (point_in),
    .out_valid (cls_valid),
    .out_stall (cls_stall),
    .out_data  (cls_data)
  );

  ucc_select u_select (
    .clk           (clk),
    .rst           (rst),
    .invalid_value (invalid_value),
    .in_valid      (cls_valid),
    .in_stall      (cls_stall),
    .in_data       (cls_data),
    .out_valid     (sel_valid),
    .out_stall     (sel_stall),
    .out_data      (sel_data)
  );

  ucc_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_stall  (sel_stall),
    .in_data   (sel_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_data)
  );

  // Drive the result ports
  assign point_out  = res_data.point_out;
  assign out_byte0  = res_data.out_byte0;
  assign out_byte1  = res_data.out_byte1;
  assign out_byte2  = res_data.out_byte2;
  assign out_byte3  = res_data.out_byte3;
  assign byte_count = res_data.byte_count;

  // A stalled classify or select stage keeps its transaction
  a_cls_hold: assert property (@(posedge clk) disable iff (rst)
    cls_valid && cls_stall |=> cls_valid)
    else $error("classify stage dropped a stalled transaction");

  a_sel_hold: assert property (@(posedge clk) disable iff (rst)
    sel_valid && sel_stall |=> sel_valid)
    else $error("select stage dropped a stalled transaction");

  // A decoded code point never comes with encoded bytes
  a_dec_no_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (point_out != '0) |-> (out_byte0 == 8'd0) && (out_byte3 == 8'd0))
    else $error("result carries both a code point and bytes");

  // Encoded bytes always come with a length
  a_bytes_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_byte0 != 8'd0) |-> (byte_count != ucc_pkg::LEN_CONT))
    else $error("encoded bytes without a length");

  // A four-byte encoding ends in a continuation byte
  a_four_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_byte0 != 8'd0) && (byte_count == ucc_pkg::LEN_4)
      |-> (out_byte3[7:6] == 2'b10))
    else $error("four-byte encoding lacks a continuation tail");

endmodule

/* tb/sv/ucc_checker.sv */
// Checker for the UTF-8 code point codec: watches the input, output and config channels, predicts and compares results.
module ucc_checker
  import ucc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CP_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              action,
  input  logic [7:0]        in_byte0,
  input  logic [7:0]        in_byte1,
  input  logic [7:0]        in_byte2,
  input  logic [7:0]        in_byte3,
  input  logic [CP_W-1:0]   point_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CP_W-1:0]   point_out,
  input  logic [7:0]        out_byte0,
  input  logic [7:0]        out_byte1,
  input  logic [7:0]        out_byte2,
  input  logic [7:0]        out_byte3,
  input  logic [CNT_W-1:0]  byte_count,
  output int unsigned       errors,
  output int unsigned       pending,
  output int unsigned       checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Local copy of the invalid_value register
  logic [CP_W-1:0] invalid_cp;
  // Results predicted for accepted transactions, oldest first
  res_t            conversions_due[$];

  initial begin
    errors  = 0;
    checked = 0;
    pending = 0;
    invalid_cp = INVALID_RESET;
  end

  function automatic logic in_surrogate_band(input logic [CP_W-1:0] v);
    return (v >= SURR_LO) && (v <= SURR_HI);
  endfunction

  // Compute the codec output for one transaction
  function automatic res_t convert_item(input logic act, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3, input logic [CP_W-1:0] cp,
                                        input logic [CP_W-1:0] inv);
    res_t            r;
    logic [CP_W-1:0] v;
    r = '0;
    if (act == ACT_DECODE) begin
      // Length from the lead byte's upper nibble
      if (!b0[7]) r.byte_count = LEN_1;
      else if (b0[7:6] == 2'b10) r.byte_count = LEN_CONT;
      else if (b0[7:5] == 3'b110) r.byte_count = LEN_2;
      else if (b0[7:4] == 4'he) r.byte_count = LEN_3;
      else r.byte_count = LEN_4;
      case (r.byte_count)
        LEN_1: r.point_out = {13'd0, b0};
        LEN_2: r.point_out = {10'd0, b0[4:0], b1[5:0]};
        LEN_3: begin
          v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
          r.point_out = in_surrogate_band(v) ? inv : v;
        end
        // Continuation lead and bad four-byte lead both give the invalid value
        default: r.point_out = ((b0 & LEAD4_MASK) == LEAD4_MARK) ?
                               {b0[2:0], b1[5:0], b2[5:0], b3[5:0]} : inv;
      endcase
    end else begin
      // Replace out-of-range and surrogate points, then encode as is
      v = ((cp > CP_MAX) || in_surrogate_band(cp)) ? inv : cp;
      if (v < LIM_1B) begin
        r.byte_count = LEN_1;
        r.out_byte0  = v[7:0];
      end else if (v < LIM_2B) begin
        r.byte_count = LEN_2;
        r.out_byte0  = LEAD2_MARK | {3'd0, v[10:6]};
        r.out_byte1  = CONT_MARK | {2'd0, v[5:0]};
      end else if (v < LIM_3B) begin
        r.byte_count = LEN_3;
        r.out_byte0  = LEAD3_MARK | {4'd0, v[15:12]};
        r.out_byte1  = CONT_MARK | {2'd0, v[11:6]};
        r.out_byte2  = CONT_MARK | {2'd0, v[5:0]};
      end else begin
        r.byte_count = LEN_4;
        r.out_byte0  = LEAD4_MARK | {5'd0, v[20:18]};
        r.out_byte1  = CONT_MARK | {2'd0, v[17:12]};
        r.out_byte2  = CONT_MARK | {2'd0, v[11:6]};
        r.out_byte3  = CONT_MARK | {2'd0, v[5:0]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                checked, name, seen, want));
  endtask

  // Track config writes, queue predictions, compare accepted results
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      conversions_due.delete();
      invalid_cp = INVALID_RESET;
      pending <= 0;
    end else begin
      if (cfg_we) invalid_cp = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (conversions_due.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = conversions_due.pop_front();
          check_field("point_out", 32'(point_out), 32'(want.point_out));
          check_field("out_byte0", 32'(out_byte0), 32'(want.out_byte0));
          check_field("out_byte1", 32'(out_byte1), 32'(want.out_byte1));
          check_field("out_byte2", 32'(out_byte2), 32'(want.out_byte2));
          check_field("out_byte3", 32'(out_byte3), 32'(want.out_byte3));
          check_field("byte_count", 32'(byte_count), 32'(want.byte_count));
          checked++;
        end
      end
      if (in_valid && !in_stall)
        conversions_due.push_back(convert_item(action, in_byte0, in_byte1, in_byte2,
                                               in_byte3, point_in, invalid_cp));
      pending <= $unsigned(conversions_due.size());
    end
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the UTF-8 code point codec: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ucc_pkg::*;

  localparam int unsigned RAND_PER_PHASE = 185;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned N_SETTINGS     = 8;

  localparam logic [CP_W-1:0] INVALID_SETTINGS [N_SETTINGS] = '{
    21'h000000, 21'h1fffff, 21'h00d800, 21'h00007f,
    21'h0007ff, 21'h00fffd, 21'h110000, 21'h00ffff
  };

  localparam int unsigned N_BOUNDARY = 14;
  localparam logic [CP_W-1:0] BOUNDARY_POINTS [N_BOUNDARY] = '{
    21'h000000, 21'h00007f, 21'h000080, 21'h0007ff, 21'h000800, 21'h00d7ff, 21'h00d800,
    21'h00dfff, 21'h00e000, 21'h00ffff, 21'h010000, 21'h10ffff, 21'h110000, 21'h1fffff
  };

  typedef struct {
    logic            act;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic [CP_W-1:0] cp;
  } codec_item_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CP_W-1:0]  cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             action    = ACT_DECODE;
  logic [7:0]       in_byte0  = '0;
  logic [7:0]       in_byte1  = '0;
  logic [7:0]       in_byte2  = '0;
  logic [7:0]       in_byte3  = '0;
  logic [CP_W-1:0]  point_in  = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CP_W-1:0]  point_out;
  logic [7:0]       out_byte0;
  logic [7:0]       out_byte1;
  logic [7:0]       out_byte2;
  logic [7:0]       out_byte3;
  logic [CNT_W-1:0] byte_count;

  int unsigned errors;
  int unsigned conversions_open;
  int unsigned checked;
  int unsigned quiet_cycles = 0;
  int unsigned n_decode     = 0;
  int unsigned n_encode     = 0;
  int unsigned n_settings   = 1;

  always #1 clk = ~clk;

  utf8_codepoint_codec_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .in_byte0   (in_byte0),
    .in_byte1   (in_byte1),
    .in_byte2   (in_byte2),
    .in_byte3   (in_byte3),
    .point_in   (point_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_out  (point_out),
    .out_byte0  (out_byte0),
    .out_byte1  (out_byte1),
    .out_byte2  (out_byte2),
    .out_byte3  (out_byte3),
    .byte_count (byte_count)
  );

  ucc_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .in_byte0   (in_byte0),
    .in_byte1   (in_byte1),
    .in_byte2   (in_byte2),
    .in_byte3   (in_byte3),
    .point_in   (point_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_out  (point_out),
    .out_byte0  (out_byte0),
    .out_byte1  (out_byte1),
    .out_byte2  (out_byte2),
    .out_byte3  (out_byte3),
    .byte_count (byte_count),
    .errors     (errors),
    .pending    (conversions_open),
    .checked    (checked)
  );

  // Decode transaction; the ignored point_in gets random content
  function automatic codec_item_t decode_item(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3);
    codec_item_t it;
    it.act = ACT_DECODE;
    it.b0  = b0;
    it.b1  = b1;
    it.b2  = b2;
    it.b3  = b3;
    it.cp  = CP_W'($urandom());
    return it;
  endfunction

  // Encode transaction; the ignored bytes get random content
  function automatic codec_item_t encode_item(input logic [CP_W-1:0] cp);
    codec_item_t it;
    it.act = ACT_ENCODE;
    it.b0  = 8'($urandom());
    it.b1  = 8'($urandom());
    it.b2  = 8'($urandom());
    it.b3  = 8'($urandom());
    it.cp  = cp;
    return it;
  endfunction

  // Mostly well-formed sequences by length class, some broken or pure noise
  function automatic codec_item_t random_item();
    codec_item_t     it;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic [CP_W-1:0] cp;
    if ($urandom_range(1) == 0) begin
      b1 = {2'b10, 6'($urandom())};
      b2 = {2'b10, 6'($urandom())};
      b3 = {2'b10, 6'($urandom())};
      case ($urandom_range(15))
        0, 1: b0 = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(8'h7f));
        2: b0 = 8'($urandom_range(8'hbf, 8'h80));
        3, 4, 5: b0 = 8'($urandom_range(8'hdf, 8'hc0));
        6, 7, 8: begin
          b0 = 8'($urandom_range(8'hef, 8'he0));
          // steer some three-byte forms into the surrogate band
          if ($urandom_range(3) == 0) begin
            b0 = 8'hed;
            b1 = 8'($urandom_range(8'hbf, 8'ha0));
          end
        end
        9, 10, 11: b0 = 8'($urandom_range(8'hf7, 8'hf0));
        12: b0 = 8'($urandom_range(8'hff, 8'hf8));
        default: begin
          b0 = 8'($urandom());
          b1 = 8'($urandom());
          b2 = 8'($urandom());
          b3 = 8'($urandom());
        end
      endcase
      it = decode_item(b0, b1, b2, b3);
    end else begin
      case ($urandom_range(11))
        0: cp = CP_W'($urandom_range(21'h00007f));
        1: cp = CP_W'($urandom_range(21'h0007ff, 21'h000080));
        2, 3: cp = CP_W'($urandom_range(21'h00ffff, 21'h000800));
        4: cp = CP_W'($urandom_range(SURR_HI, SURR_LO));
        5, 6: cp = CP_W'($urandom_range(CP_MAX, LIM_3B));
        7, 8: cp = CP_W'($urandom_range(21'h1fffff, 21'h110000));
        9: cp = BOUNDARY_POINTS[$urandom_range(N_BOUNDARY - 1)];
        default: cp = CP_W'($urandom());
      endcase
      it = encode_item(cp);
    end
    return it;
  endfunction

  // Mostly back to back or short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Present one transaction after an optional gap and hold it until accepted
  task automatic send_item(input codec_item_t it, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= it.act;
    in_byte0 <= it.b0;
    in_byte1 <= it.b1;
    in_byte2 <= it.b2;
    in_byte3 <= it.b3;
    point_in <= it.cp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.act == ACT_ENCODE) n_encode++;
    else n_decode++;
  endtask

  // Drop valid and wait until every outstanding transaction has come back
  task automatic drain(input int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (conversions_open != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_invalid(input logic [CP_W-1:0] value);
    drain(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int unsigned count);
    bit calm;
    calm = 0;
    for (int unsigned i = 0; i < count; i++) begin
      // switch between gapped and back-to-back stretches
      if (i % 48 == 0) calm = ($urandom_range(3) == 0);
      send_item(random_item(), pick_gap(calm));
    end
  endtask

  // Random output stalls: calm stretches, short flickers, occasional long holds
  initial begin : stall_gen
    int unsigned span;
    @(posedge clk);
    forever begin
      case ($urandom_range(15))
        0, 1: begin
          out_stall <= 1'b0;
          span = $urandom_range(150, 20);
        end
        2: begin
          out_stall <= 1'b1;
          span = $urandom_range(60, 15);
        end
        3, 4, 5, 6, 7, 8: begin
          out_stall <= 1'b1;
          span = $urandom_range(3, 1);
        end
        default: begin
          out_stall <= 1'b0;
          span = $urandom_range(4, 1);
        end
      endcase
      repeat (span) @(posedge clk);
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed decode: NUL, ASCII edge, continuation leads, each length,
    // surrogate band, values above the code space, bad four-byte leads
    send_item(decode_item(8'h00, 8'h00, 8'h00, 8'h00), pick_gap(0));
    send_item(decode_item(8'h7f, 8'hff, 8'hff, 8'hff), pick_gap(0));
    send_item(decode_item(8'h80, 8'h80, 8'h80, 8'h80), pick_gap(0));
    send_item(decode_item(8'hbf, 8'hbf, 8'hbf, 8'hbf), pick_gap(0));
    send_item(decode_item(8'hc2, 8'ha9, 8'h00, 8'h00), pick_gap(0));
    send_item(decode_item(8'hdf, 8'hbf, 8'h00, 8'h00), pick_gap(0));
    send_item(decode_item(8'he0, 8'h80, 8'h80, 8'h00), pick_gap(0));
    send_item(decode_item(8'hed, 8'ha0, 8'h80, 8'h00), pick_gap(0));
    send_item(decode_item(8'hed, 8'hbf, 8'hbf, 8'h00), pick_gap(0));
    send_item(decode_item(8'hef, 8'hbf, 8'hbf, 8'hff), pick_gap(0));
    send_item(decode_item(8'hf4, 8'h8f, 8'hbf, 8'hbf), pick_gap(0));
    send_item(decode_item(8'hf7, 8'hbf, 8'hbf, 8'hbf), pick_gap(0));
    send_item(decode_item(8'hf8, 8'h80, 8'h80, 8'h80), pick_gap(0));
    send_item(decode_item(8'hff, 8'hff, 8'hff, 8'hff), pick_gap(0));

    // Directed encode: every length boundary, surrogates, out of range
    for (int unsigned i = 0; i < N_BOUNDARY; i++)
      send_item(encode_item(BOUNDARY_POINTS[i]), pick_gap(0));

    // Random traffic under the reset setting, then under each written setting
    run_random(RAND_PER_PHASE);
    for (int unsigned p = 0; p <= N_SETTINGS; p++) begin
      write_invalid((p == N_SETTINGS) ? CP_W'($urandom()) : INVALID_SETTINGS[p]);
      run_random(RAND_PER_PHASE);
    end

    drain(DRAIN_CYCLES);
    $display("Run covered %0d decode and %0d encode transactions over %0d invalid_value settings",
             n_decode, n_encode, n_settings);
    $display("Compared %0d results, %0d mismatches", checked, errors);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
